[hdl/pgca_pkg.sv]
`default_nettype none

package pgca_pkg;

    // command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_TABLE = 1'b1;

    // gamma table channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // register map (index = paddr[3:2])
    localparam int          ADDR_W       = 4;
    localparam logic [1:0]  REG_LUT_EN   = 2'd0;
    localparam logic [1:0]  REG_BRIGHT   = 2'd1;
    localparam logic [1:0]  REG_CONTRAST = 2'd2;
    localparam logic [1:0]  REG_SAT      = 2'd3;

    localparam int BYTE_W    = 8;
    localparam int TBL_DEPTH = 256;

    // datapath widths
    localparam int FAC_W     = 9;   // 100 + pct
    localparam int NUM_W     = 18;  // contrast numerator
    localparam int X2_W      = 11;  // contrast result
    localparam int LUM_W     = 21;  // luminance * 1000
    localparam int DIFF_W    = 22;  // 1000*x - lum
    localparam int SAT_W     = 32;  // saturation numerator
    localparam int SAT_MAG_W = 25;  // numerator below the clamp limit

    // divide by 100: floor(a * 167773 / 2^24), exact for a < 199728
    localparam logic [17:0] DIV100_MUL = 18'd167773;
    localparam int          DIV100_SH  = 24;

    // divide by 100000: floor(a * 43980466 / 2^42), exact for a < 2^25
    localparam logic [25:0] DIV1E5_MUL = 26'd43980466;
    localparam int          DIV1E5_SH  = 42;

    // numerators at or above this give 256 or more
    localparam logic signed [SAT_W-1:0] SAT_CLAMP_NUM = 32'sd25600000;

    localparam logic signed [LUM_W-1:0] LUM_R_COEF = 21'sd299;
    localparam logic signed [LUM_W-1:0] LUM_G_COEF = 21'sd587;
    localparam logic signed [LUM_W-1:0] LUM_B_COEF = 21'sd114;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_stage_en;

    typedef struct packed {
        logic              fe;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] g;
        logic [BYTE_W-1:0] b;
    } t_side;

    // (100 + pct), pct signed 8 bit
    function automatic logic signed [FAC_W-1:0] pct_factor(input logic signed [7:0] pct);
        return $signed({pct[7], pct}) + 9'sd100;
    endfunction

endpackage

`default_nettype wire

[hdl/pgca_ram.sv]
`default_nettype none

module pgca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/pgca_contrast.sv]
`default_nettype none

module pgca_contrast (
    input  wire logic                                  i_clk,
    input  wire pgca_pkg::t_stage_en                   i_en,
    input  wire logic [pgca_pkg::BYTE_W-1:0]           i_x,
    input  wire logic signed [7:0]                     i_bright,
    input  wire logic signed [7:0]                     i_contrast,
    output logic signed [pgca_pkg::X2_W-1:0]           o_x2
);
    import pgca_pkg::*;

    logic signed [9:0]         n_t;
    logic signed [FAC_W-1:0]   n_k;
    logic signed [18:0]        n_prod;
    logic signed [NUM_W-1:0]   n_num;
    logic signed [NUM_W-1:0]   r_num;
    logic                      n_neg;
    logic [NUM_W-2:0]          n_mag;
    logic [34:0]               n_scaled;
    logic [X2_W-1:0]           n_quo;
    logic signed [X2_W-1:0]    n_x2;
    logic signed [X2_W-1:0]    r_x2;

    // stage 2: (x + B - 128) * (100 + C) + 12800
    always_comb begin
        n_t    = $signed({2'b00, i_x}) + $signed({{2{i_bright[7]}}, i_bright}) - 10'sd128;
        n_k    = pct_factor(i_contrast);
        n_prod = 19'(n_t) * 19'(n_k);
        n_num  = NUM_W'(n_prod + 19'sd12800);
    end

    // stage 3: truncating divide by 100 on the magnitude
    always_comb begin
        n_neg    = r_num[NUM_W-1];
        n_mag    = n_neg ? (NUM_W-1)'(-r_num) : (NUM_W-1)'(r_num);
        n_scaled = n_mag * DIV100_MUL;
        n_quo    = n_scaled[DIV100_SH +: X2_W];
        n_x2     = n_neg ? -$signed(n_quo) : $signed(n_quo);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_num <= n_num;
        end
        if (i_en.s3) begin
            r_x2 <= n_x2;
        end
    end

    assign o_x2 = r_x2;

endmodule

`default_nettype wire

[hdl/pgca_saturate.sv]
`default_nettype none

module pgca_saturate (
    input  wire logic                                  i_clk,
    input  wire pgca_pkg::t_stage_en                   i_en,
    input  wire logic signed [pgca_pkg::X2_W-1:0]      i_x2,
    input  wire logic signed [pgca_pkg::LUM_W-1:0]     i_lum,
    input  wire logic signed [7:0]                     i_sat,
    input  wire logic [pgca_pkg::BYTE_W-1:0]           i_x_byp,
    input  wire logic                                  i_adj_on,
    output logic [pgca_pkg::BYTE_W-1:0]                o_y
);
    import pgca_pkg::*;

    logic signed [DIFF_W-1:0]  n_diff;
    logic signed [FAC_W-1:0]   n_k;
    logic signed [SAT_W-1:0]   n_num;
    logic signed [SAT_W-1:0]   r_num;
    logic [50:0]               n_scaled;
    logic [BYTE_W-1:0]         n_sat;
    logic [BYTE_W-1:0]         n_y;
    logic [BYTE_W-1:0]         r_y;

    // stage 5: 100*L + (100 + S) * (1000*x - L)
    always_comb begin
        n_k    = pct_factor(i_sat);
        n_diff = DIFF_W'(i_x2) * 22'sd1000 - DIFF_W'(i_lum);
        n_num  = SAT_W'(n_diff) * SAT_W'(n_k) + SAT_W'(i_lum) * 32'sd100;
    end

    // stage 6: divide by 100000 and clamp; negative gives 0; bypass byte when adjust is off
    always_comb begin
        n_scaled = r_num[SAT_MAG_W-1:0] * DIV1E5_MUL;
        priority if (r_num[SAT_W-1]) begin
            n_sat = '0;
        end else if (r_num >= SAT_CLAMP_NUM) begin
            n_sat = '1;
        end else begin
            n_sat = n_scaled[DIV1E5_SH +: BYTE_W];
        end
        n_y = i_adj_on ? n_sat : i_x_byp;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_num <= n_num;
        end
        if (i_en.s6) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

`default_nettype wire

[hdl/pixel_gamma_colour_adjust.sv]
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   command, pixel, frame end, table write
// output    out        o_out_valid / i_out_ready pixel result, frame end
// config    in         psel / penable / pready   paddr, pwdata, prdata (APB-style)
//
// One transaction per clock sustained while the output is not stalled. After
// acceptance a pixel goes through gamma RAM read, contrast multiply, divide by
// 100, luminance, saturation multiply, divide by 100000 and clamp, in order.
// A table write leaves no result.
// Reset (i_rst_n low, synchronous) clears the valid bits and the registers; the
// gamma tables are not cleared and must be written before lut_enable is used.
// Each stage holds while the one after it is full and stalled, so bubbles close up.

module pixel_gamma_colour_adjust (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pgca_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_command,
    input  wire logic [31:0]                    i_pixel_word,
    input  wire logic                           i_frame_end,
    input  wire logic [1:0]                     i_table_channel,
    input  wire logic [7:0]                     i_table_index,
    input  wire logic [7:0]                     i_table_value,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [31:0]                         o_pixel_result,
    output logic                                o_frame_end_out
);
    import pgca_pkg::*;

    // config registers
    logic                    r_lut_en;
    logic signed [7:0]       r_bright;
    logic signed [7:0]       r_contrast;
    logic signed [7:0]       r_sat;
    logic                    cfg_wr;
    logic                    adj_on;

    // pipeline control
    t_stage_en               en;
    logic [6:1]              r_v;
    logic                    in_acc;
    logic                    tbl_wr;

    // sideband pipeline: alpha, frame end, bypass colour
    t_side                   r_side1, r_side2, r_side3, r_side4, r_side5;
    logic [BYTE_W-1:0]       r_a6;
    logic                    r_fe6;

    logic [BYTE_W-1:0]       raw  [3];
    logic [BYTE_W-1:0]       tbl_q [3];
    logic [BYTE_W-1:0]       mapped [3];
    logic signed [X2_W-1:0]  x2 [3];
    logic signed [X2_W-1:0]  r_x2_4 [3];
    logic signed [LUM_W-1:0] n_lum;
    logic signed [LUM_W-1:0] r_lum;
    logic [BYTE_W-1:0]       byp5 [3];
    logic [BYTE_W-1:0]       y [3];

    // ---------------------------------------------------------------- config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lut_en   <= 1'b0;
            r_bright   <= '0;
            r_contrast <= '0;
            r_sat      <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_LUT_EN:   r_lut_en   <= pwdata[0];
                REG_BRIGHT:   r_bright   <= $signed(pwdata[7:0]);
                REG_CONTRAST: r_contrast <= $signed(pwdata[7:0]);
                REG_SAT:      r_sat      <= $signed(pwdata[7:0]);
                default:      r_lut_en   <= r_lut_en;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LUT_EN:   prdata = {31'd0, r_lut_en};
            REG_BRIGHT:   prdata = {24'd0, r_bright};
            REG_CONTRAST: prdata = {24'd0, r_contrast};
            REG_SAT:      prdata = {24'd0, r_sat};
            default:      prdata = '0;
        endcase
    end

    // adjust path is skipped entirely when all three registers are zero
    assign adj_on = (r_bright != '0) || (r_contrast != '0) || (r_sat != '0);

    // ---------------------------------------------------------------- stage enables
    // a stage loads when empty or when its contents move on
    always_comb begin
        en.s6 = !r_v[6] || i_out_ready;
        en.s5 = !r_v[5] || en.s6;
        en.s4 = !r_v[4] || en.s5;
        en.s3 = !r_v[3] || en.s4;
        en.s2 = !r_v[2] || en.s3;
        en.s1 = !r_v[1] || en.s2;
    end

    assign o_in_ready = en.s1;
    assign in_acc     = i_in_valid && o_in_ready;
    assign tbl_wr     = in_acc && (i_command == CMD_TABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en.s1) r_v[1] <= in_acc && (i_command == CMD_PIXEL);
            if (en.s2) r_v[2] <= r_v[1];
            if (en.s3) r_v[3] <= r_v[2];
            if (en.s4) r_v[4] <= r_v[3];
            if (en.s5) r_v[5] <= r_v[4];
            if (en.s6) r_v[6] <= r_v[5];
        end
    end

    // ---------------------------------------------------------------- sideband
    assign raw[0] = r_side1.r;
    assign raw[1] = r_side1.g;
    assign raw[2] = r_side1.b;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mapped[c] = r_lut_en ? tbl_q[c] : raw[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_side1 <= {i_frame_end, i_pixel_word};
        end
        if (en.s2) begin
            r_side2 <= {r_side1.fe, r_side1.a, mapped[0], mapped[1], mapped[2]};
        end
        if (en.s3) r_side3 <= r_side2;
        if (en.s4) r_side4 <= r_side3;
        if (en.s5) r_side5 <= r_side4;
        if (en.s6) begin
            r_a6  <= r_side5.a;
            r_fe6 <= r_side5.fe;
        end
    end

    assign byp5[0] = r_side5.r;
    assign byp5[1] = r_side5.g;
    assign byp5[2] = r_side5.b;

    // ---------------------------------------------------------------- luminance (stage 4)
    always_comb begin
        n_lum = LUM_W'(x2[0]) * LUM_R_COEF
              + LUM_W'(x2[1]) * LUM_G_COEF
              + LUM_W'(x2[2]) * LUM_B_COEF;
    end

    always_ff @(posedge i_clk) begin
        if (en.s4) begin
            r_lum <= n_lum;
            for (int c = 0; c < 3; c++) begin
                r_x2_4[c] <= x2[c];
            end
        end
    end

    // ---------------------------------------------------------------- per-channel units
    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic tbl_we;
        assign tbl_we = tbl_wr && (i_table_channel == 2'(c));

        // gamma table; read on acceptance so data lines up with stage 1
        pgca_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (TBL_DEPTH)
        ) u_tbl (
            .i_clk   (i_clk),
            .i_we    (tbl_we),
            .i_waddr (i_table_index),
            .i_wdata (i_table_value),
            .i_re    (en.s1),
            .i_raddr (i_pixel_word[(2-c)*BYTE_W +: BYTE_W]),
            .o_rdata (tbl_q[c])
        );

        pgca_contrast u_contrast (
            .i_clk      (i_clk),
            .i_en       (en),
            .i_x        (mapped[c]),
            .i_bright   (r_bright),
            .i_contrast (r_contrast),
            .o_x2       (x2[c])
        );

        pgca_saturate u_saturate (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_x2     (r_x2_4[c]),
            .i_lum    (r_lum),
            .i_sat    (r_sat),
            .i_x_byp  (byp5[c]),
            .i_adj_on (adj_on),
            .o_y      (y[c])
        );
    end

    // ---------------------------------------------------------------- output
    assign o_out_valid     = r_v[6];
    assign o_pixel_result  = {r_a6, y[0], y[1], y[2]};
    assign o_frame_end_out = r_fe6;

    // ---------------------------------------------------------------- assertions
    // a table write never becomes a pipeline transaction
    a_tbl_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_command == CMD_TABLE)) |=> !r_v[1])
        else $error("table write entered the pixel pipeline");

    // an accepted pixel always occupies stage 1 next cycle
    a_pix_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_command == CMD_PIXEL)) |=> r_v[1])
        else $error("accepted pixel lost at stage 1");

    // back-pressure only when every stage is full and the output is stalled
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> ((&r_v) && !i_out_ready))
        else $error("input stalled with a bubble in the pipeline");

    // a held mid-pipeline stage keeps its contents
    a_stage3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && !en.s3) |=> (r_v[3] && $stable(x2[0]) && $stable(r_side3)))
        else $error("stalled stage changed");

endmodule

`default_nettype wire

[dv/testbench.sv]
module testbench;
    import pgca_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 9;
    // pipeline is six deep; a table write in flight leaves no result behind
    localparam int SETTLE_CYCLES  = 12;
    localparam int TIMEOUT_CYCLES = 400_000;

    // table channel code that selects no table
    localparam logic [1:0] CH_UNUSED = 2'd3;

    // one input transaction
    typedef struct packed {
        logic        cmd;
        logic [31:0] word;
        logic        fe;
        logic [1:0]  chan;
        logic [7:0]  idx;
        logic [7:0]  val;
    } t_txn;

    // one output transaction
    typedef struct packed {
        logic [31:0] word;
        logic        fe;
    } t_px_out;

    // directed stimulus row: either a register write or a transaction,
    // with the result typed in where it is obvious
    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  sel;
        logic [7:0]  cfg_val;
        t_txn        txn;
        logic        typed;
        logic [31:0] want;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_command = CMD_PIXEL;
    logic [31:0]          i_pixel_word = '0;
    logic                 i_frame_end = 1'b0;
    logic [1:0]           i_table_channel = CH_RED;
    logic [7:0]           i_table_index = '0;
    logic [7:0]           i_table_value = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [31:0]          o_pixel_result;
    logic                 o_frame_end_out;

    // typed expectation travelling with the transaction on the input
    logic                 drv_typed = 1'b0;
    logic [31:0]          drv_want = '0;

    // shadow of the register file and the gamma tables
    logic                 lut_on_sh = 1'b0;
    logic signed [7:0]    bright_sh = '0;
    logic signed [7:0]    contrast_sh = '0;
    logic signed [7:0]    sat_sh = '0;
    logic [7:0]           gamma_shadow [3][256];
    logic                 entry_known [3][256];
    logic [7:0]           known_entries [3][$];

    t_px_out              pending_pixels [$];
    t_dir_row             dir_rows [$];

    // idle and stall control, shared with the sender and receiver
    int                   tx_idle_pct = 0;
    int                   rx_stall_pct = 0;
    int                   rx_hold_left = 0;

    int                   mismatches = 0;
    int                   pixels_sent = 0;
    int                   table_writes = 0;
    int                   unused_writes = 0;
    int                   results_seen = 0;
    int                   cfg_writes = 0;

    pixel_gamma_colour_adjust dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_pixel_word    (i_pixel_word),
        .i_frame_end     (i_frame_end),
        .i_table_channel (i_table_channel),
        .i_table_index   (i_table_index),
        .i_table_value   (i_table_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_result  (o_pixel_result),
        .o_frame_end_out (o_frame_end_out)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Colour predictor: gamma lookup, then brightness, contrast around 128
    // and saturation toward the 299/587/114 luminance, all in exact integer
    // maths with truncation toward zero, clamped to a byte at the end.
    // ---------------------------------------------------------------------
    function automatic logic [31:0] adjusted_pixel(input logic [31:0] w);
        logic [7:0] chv [3];
        longint     x2 [3];
        longint     boff;
        longint     cfac;
        longint     sfac;
        longint     lum;
        longint     x3;
        chv[0] = w[23:16];
        chv[1] = w[15:8];
        chv[2] = w[7:0];
        boff = bright_sh;
        cfac = 100 + contrast_sh;
        sfac = 100 + sat_sh;
        if (lut_on_sh) begin
            for (int i = 0; i < 3; i++) chv[i] = gamma_shadow[i][chv[i]];
        end
        // all three adjust registers at zero: stage bypassed
        if (bright_sh != 0 || contrast_sh != 0 || sat_sh != 0) begin
            for (int i = 0; i < 3; i++) begin
                x2[i] = ((longint'(chv[i]) + boff - 128) * cfac + 12800) / 100;
            end
            lum = 299 * x2[0] + 587 * x2[1] + 114 * x2[2];
            for (int i = 0; i < 3; i++) begin
                x3 = (100 * lum + sfac * (1000 * x2[i] - lum)) / 100000;
                chv[i] = (x3 < 0) ? 8'd0 : (x3 > 255) ? 8'd255 : x3[7:0];
            end
        end
        return {w[31:24], chv[0], chv[1], chv[2]};
    endfunction

    function automatic t_dir_row row_px(input logic [31:0] word, input logic fe,
                                        input logic typed, input logic [31:0] want);
        t_dir_row r;
        r = '0;
        r.txn.cmd  = CMD_PIXEL;
        r.txn.word = word;
        r.txn.fe   = fe;
        r.txn.chan = 2'($urandom_range(3));
        r.txn.idx  = 8'($urandom_range(255));
        r.txn.val  = 8'($urandom_range(255));
        r.typed    = typed;
        r.want     = want;
        return r;
    endfunction

    function automatic t_dir_row row_wr(input logic [1:0] chan, input logic [7:0] idx,
                                        input logic [7:0] val);
        t_dir_row r;
        r = '0;
        r.txn.cmd  = CMD_TABLE;
        r.txn.word = $urandom;
        r.txn.fe   = 1'($urandom_range(1));
        r.txn.chan = chan;
        r.txn.idx  = idx;
        r.txn.val  = val;
        return r;
    endfunction

    function automatic t_dir_row row_cfg(input logic [1:0] sel, input logic [7:0] v);
        t_dir_row r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.sel     = sel;
        r.cfg_val = v;
        return r;
    endfunction

    // byte with a fair share of the extremes
    function automatic logic [7:0] rand_level();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // any table entry already written, so a lookup never hits an unknown one
    function automatic logic [7:0] pick_entry(input logic [1:0] ch);
        return known_entries[ch][$urandom_range(known_entries[ch].size() - 1)];
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // APB write: setup then access; the register takes the value at the
    // edge where the access phase meets pready, then the bus goes idle
    task automatic reg_write(input logic [1:0] sel, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= (sel == REG_LUT_EN) ? {31'd0, v[0]} : {{24{v[7]}}, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (sel)
            REG_LUT_EN:   lut_on_sh   = v[0];
            REG_BRIGHT:   bright_sh   = v;
            REG_CONTRAST: contrast_sh = v;
            REG_SAT:      sat_sh      = v;
            default: ;
        endcase
        cfg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one transaction and return at the edge that accepts it. Valid
    // only drops when a gap is inserted, so back-to-back items keep it high.
    task automatic send_txn(input t_txn t, input logic typed, input logic [31:0] want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= t.cmd;
        i_pixel_word    <= t.word;
        i_frame_end     <= t.fe;
        i_table_channel <= t.chan;
        i_table_index   <= t.idx;
        i_table_value   <= t.val;
        drv_typed       <= typed;
        drv_want        <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Block idle: nothing pending and any trailing table write retired.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One random phase under a fixed register setting. A quarter of the
    // transactions are table writes (a quarter of those to the unused
    // channel); with the tables enabled pixels only hit written entries.
    task automatic run_phase(input logic lut, input logic [7:0] b, input logic [7:0] c,
                             input logic [7:0] s, input int tx_pct, input int rx_pct,
                             input int hold, input int n);
        t_txn t;
        reg_write(REG_LUT_EN, {7'd0, lut});
        reg_write(REG_BRIGHT, b);
        reg_write(REG_CONTRAST, c);
        reg_write(REG_SAT, s);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        rx_hold_left = hold;
        repeat (n) begin
            t.cmd  = ($urandom_range(3) == 0) ? CMD_TABLE : CMD_PIXEL;
            t.word = $urandom;
            t.fe   = ($urandom_range(7) == 0);
            t.chan = 2'($urandom_range(3));
            t.idx  = 8'($urandom_range(255));
            t.val  = rand_level();
            if (t.cmd == CMD_PIXEL) begin
                if (lut_on_sh) begin
                    t.word[23:0] = {pick_entry(CH_RED), pick_entry(CH_GREEN),
                                    pick_entry(CH_BLUE)};
                end else begin
                    t.word[23:0] = {rand_level(), rand_level(), rand_level()};
                end
            end
            send_txn(t, 1'b0, '0);
        end
        settle();
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watch both channels. Input side first, so an expectation queued in the
    // same step is already in the queue when a result is checked.
    always @(posedge i_clk) begin : watch
        t_px_out exp_px;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (i_command == CMD_TABLE) begin
                    table_writes++;
                    if (i_table_channel != CH_UNUSED) begin
                        gamma_shadow[i_table_channel][i_table_index] = i_table_value;
                        if (!entry_known[i_table_channel][i_table_index]) begin
                            entry_known[i_table_channel][i_table_index] = 1'b1;
                            known_entries[i_table_channel].push_back(i_table_index);
                        end
                    end else begin
                        unused_writes++;
                    end
                end else begin
                    pixels_sent++;
                    exp_px.word = drv_typed ? drv_want : adjusted_pixel(i_pixel_word);
                    exp_px.fe   = i_frame_end;
                    pending_pixels.push_back(exp_px);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_pixels.size() == 0) begin
                    flag_mismatch($sformatf("result %h with no pixel pending",
                                            o_pixel_result));
                end else begin
                    exp_px = pending_pixels.pop_front();
                    results_seen++;
                    if (o_pixel_result !== exp_px.word) begin
                        flag_mismatch($sformatf("pixel_result %h, want %h",
                                                o_pixel_result, exp_px.word));
                    end
                    if (o_frame_end_out !== exp_px.fe) begin
                        flag_mismatch($sformatf("frame_end_out %b, want %b (pixel %h)",
                                                o_frame_end_out, exp_px.fe, exp_px.word));
                    end
                end
            end
        end
    end

    initial begin : stimulus
        for (int c = 0; c < 3; c++) begin
            for (int e = 0; e < 256; e++) entry_known[c][e] = 1'b0;
        end

        dir_rows = '{
            // out of reset everything is bypassed: pixel comes back as sent
            row_px(32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000),
            row_px(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF),
            row_px(32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678),
            // both ends of each table, then a write to the unused channel
            // that must not land in blue
            row_wr(CH_RED,   8'h00, 8'hFF),
            row_wr(CH_RED,   8'hFF, 8'h00),
            row_wr(CH_GREEN, 8'h00, 8'h80),
            row_wr(CH_GREEN, 8'hFF, 8'h7F),
            row_wr(CH_BLUE,  8'h00, 8'h01),
            row_wr(CH_BLUE,  8'hFF, 8'hFE),
            row_wr(CH_UNUSED, 8'h00, 8'h55),
            row_cfg(REG_LUT_EN, 8'h01),
            row_px(32'hA5FF_00FF, 1'b1, 1'b1, 32'hA500_80FE),
            row_px(32'h5A00_FF00, 1'b0, 1'b1, 32'h5AFF_7F01),
            row_cfg(REG_LUT_EN, 8'h00),
            // brightness alone shifts each channel; clamps at both ends
            row_cfg(REG_BRIGHT, 8'h7F),
            row_px(32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF),
            row_px(32'h8000_0000, 1'b1, 1'b1, 32'h807F_7F7F),
            row_cfg(REG_BRIGHT, 8'h80),
            row_px(32'h01FF_FFFF, 1'b0, 1'b1, 32'h017F_7F7F),
            row_px(32'h0180_4000, 1'b0, 1'b1, 32'h0100_0000),
            row_cfg(REG_BRIGHT, 8'h00),
            // contrast -128 gives a negative factor; 127 more than doubles
            row_cfg(REG_CONTRAST, 8'h80),
            row_px(32'h00FF_8000, 1'b0, 1'b0, '0),
            row_px(32'hFF10_20F0, 1'b1, 1'b0, '0),
            row_cfg(REG_CONTRAST, 8'h7F),
            row_px(32'h00FF_8000, 1'b0, 1'b0, '0),
            row_px(32'h3381_7F7E, 1'b1, 1'b0, '0),
            row_cfg(REG_CONTRAST, 8'h00),
            // saturation extremes: past grey and strongly boosted
            row_cfg(REG_SAT, 8'h80),
            row_px(32'h00FF_0000, 1'b0, 1'b0, '0),
            row_px(32'h0000_FF80, 1'b1, 1'b0, '0),
            row_cfg(REG_SAT, 8'h7F),
            row_px(32'h0000_00FF, 1'b0, 1'b0, '0),
            row_px(32'h00C0_4020, 1'b1, 1'b0, '0),
            row_cfg(REG_SAT, 8'h00)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: register writes only once the block has drained
        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                settle();
                reg_write(dir_rows[r].sel, dir_rows[r].cfg_val);
            end else begin
                send_txn(dir_rows[r].txn, dir_rows[r].typed, dir_rows[r].want);
            end
        end
        settle();

        // random part: register extremes and random settings, with the
        // four idle/stall mixes rotated over the phases
        run_phase(1'b0, 8'h00, 8'h00, 8'h00,  0,  0,   0, 155);
        run_phase(1'b1, 8'h00, 8'h00, 8'h00, 55,  0,   0, 155);
        run_phase(1'b1, 8'h7F, 8'h80, 8'h7F,  0, 55,   0, 155);
        run_phase(1'b0, 8'h80, 8'h7F, 8'h80, 27, 27,   0, 155);
        // long output hold-off with the sender flat out: input must stall
        run_phase(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 0, 0, 300, 155);
        run_phase(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 55, 0, 0, 155);
        run_phase(1'b1, 8'h80, 8'h80, 8'h80,  0, 55,   0, 155);
        run_phase(1'b0, 8'h7F, 8'h7F, 8'h7F, 27, 27,   0, 155);

        $display("Covered %0d pixel transactions (%0d results checked), %0d table writes",
                 pixels_sent, results_seen, table_writes);
        $display("(%0d to the unused channel), %0d register writes incl. extremes, %0d errors",
                 unused_writes, cfg_writes, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
